// ===== design/sitda_pkg.sv =====
// Shared constants, types and elaboration helpers for the signed integer to
// decimal ASCII converter. No dependencies.

package sitda_pkg;

    // Default operand width of the converter.
    localparam int VALUE_BITS_DEFAULT = 32;

    // Double-dabble shift steps done in each pipeline stage.
    localparam int STEP_BITS = 4;

    // Digit code width.
    localparam int DIGIT_W = 4;

    // Character width on the output side.
    localparam int CHAR_W = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // One output character and its end-of-number mark.
    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last_char;
    } char_beat_t;

    // Decimal digits of 2^(bits-1), the largest magnitude; used at
    // elaboration only. 30103/100000 approximates log10(2).
    function automatic int dec_digits(input int bits);
        return ((bits - 1) * 30103) / 100000 + 1;
    endfunction

endpackage

// ===== design/sitda_negate.sv =====
// First pipeline stage: strips the sign and forms the unsigned magnitude.
// Depends on sitda_pkg for the default operand width.

module sitda_negate #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT,
    parameter int BIN_W      = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BIN_W-1:0]      out_bin,
    output logic                  out_neg
);

    logic                  valid_reg;
    logic [BIN_W-1:0]      bin_reg;
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] mag_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_bin   = bin_reg;
    assign out_neg   = neg_reg;

    // Unsigned magnitude: the most negative value maps onto 2^(N-1).
    assign mag_next = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bin_reg <= BIN_W'(mag_next);
            neg_reg <= in_value[VALUE_BITS-1];
        end
    end

endmodule

// ===== design/sitda_dabble_stage.sv =====
// One double-dabble pipeline stage: STEP_BITS add-3/shift steps per beat.
// Depends on sitda_pkg for STEP_BITS and DIGIT_W.

module sitda_dabble_stage #(
    parameter int DIGITS = 10,
    parameter int BIN_W  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [DIGITS*sitda_pkg::DIGIT_W-1:0] in_bcd,
    input  logic [BIN_W-1:0]                     in_bin,
    input  logic                                 in_neg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [DIGITS*sitda_pkg::DIGIT_W-1:0] out_bcd,
    output logic [BIN_W-1:0]                     out_bin,
    output logic                                 out_neg
);

    localparam int BCD_W = DIGITS * sitda_pkg::DIGIT_W;

    logic             valid_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BIN_W-1:0] bin_reg;
    logic             neg_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [BIN_W-1:0] bin_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_bcd   = bcd_reg;
    assign out_bin   = bin_reg;
    assign out_neg   = neg_reg;

    // Binary bits enter the BCD field from the top of bin, MSB first.
    always_comb
    begin
        bcd_next = in_bcd;
        bin_next = in_bin;
        for (int s = 0; s < sitda_pkg::STEP_BITS; s++)
        begin
            for (int d = 0; d < DIGITS; d++)
            begin
                if (bcd_next[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] >= 4'd5)
                begin
                    bcd_next[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] =
                        bcd_next[d*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] + 4'd3;
                end
            end
            {bcd_next, bin_next} = {bcd_next[BCD_W-2:0], bin_next, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bcd_reg <= bcd_next;
            bin_reg <= bin_next;
            neg_reg <= in_neg;
        end
    end

endmodule

// ===== design/sitda_emitter.sv =====
// Character serializer: holds one number's digits and sends sign and digits
// MSB first through a registered output. Depends on sitda_pkg.

module sitda_emitter #(
    parameter int DIGITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [DIGITS*sitda_pkg::DIGIT_W-1:0] in_bcd,
    input  logic                                 in_neg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sitda_pkg::char_beat_t                out_beat
);

    localparam int POS_W = $clog2(DIGITS);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          sign_pend_reg;
    logic [POS_W-1:0]              pos_reg;
    logic [sitda_pkg::DIGIT_W-1:0] digit_reg [DIGITS];
    logic                          valid_reg;
    logic                          valid_next;
    sitda_pkg::char_beat_t         beat_reg;
    sitda_pkg::char_beat_t         beat_next;
    logic [POS_W-1:0]              top_idx;
    logic                          advance;
    logic                          finish;
    logic                          load;

    assign advance   = busy_reg && (!valid_reg || out_ready);
    assign finish    = advance && !sign_pend_reg && (pos_reg == '0);
    assign in_ready  = !busy_reg || finish;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

    // Highest nonzero digit; zero itself prints as one digit.
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < DIGITS; i++)
        begin
            if (in_bcd[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W] != '0)
            begin
                top_idx = POS_W'(i);
            end
        end
    end

    always_comb
    begin
        beat_next  = beat_reg;
        valid_next = valid_reg;
        busy_next  = busy_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            if (sign_pend_reg)
            begin
                beat_next.character = sitda_pkg::CHAR_MINUS;
                beat_next.last_char = 1'b0;
            end
            else
            begin
                beat_next.character = sitda_pkg::CHAR_ZERO
                                    + {2'b00, digit_reg[pos_reg]};
                beat_next.last_char = (pos_reg == '0);
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (finish)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        if (advance)
        begin
            if (sign_pend_reg)
            begin
                sign_pend_reg <= 1'b0;
            end
            else if (pos_reg != '0)
            begin
                pos_reg <= pos_reg - 1'b1;
            end
        end
        if (load)
        begin
            sign_pend_reg <= in_neg;
            pos_reg       <= top_idx;
            for (int i = 0; i < DIGITS; i++)
            begin
                digit_reg[i] <= in_bcd[i*sitda_pkg::DIGIT_W +: sitda_pkg::DIGIT_W];
            end
        end
    end

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg, sitda_negate, sitda_dabble_stage and sitda_emitter.
//
// Usage:
//   Slave channel (s_*): one beat carries one signed integer in the low
//   VALUE_BITS bits of s_tdata; higher bits are ignored.
//   Master channel (m_*): one beat per character, most significant digit
//   first, a leading '-' for negative values, no leading zeros, '0' for zero.
//   m_tlast marks the last character of each number.
//   Pipeline: one magnitude stage, then ceil(VALUE_BITS/4) double-dabble
//   stages of four shift steps each, then the character serializer. A
//   number's first character passes through the magnitude register, each
//   dabble stage register, the serializer's digit register and its output register.
//   Throughput: the serializer sends one character per cycle while the output
//   is not stalled and loads the next number while sending the last
//   character of the current one; at 32 bits a number has 1 to 11 characters.
//   The pipeline stages accept a new beat every cycle until they fill.
//   Stall: when m_tready is low the output register holds its beat, the
//   serializer pauses, and backpressure ripples stage by stage to s_tready;
//   nothing is dropped or repeated.
//   Reset (rst_n low, asynchronous): all valid flags clear, pending numbers
//   are discarded; no clearing pass is needed.

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitda_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata fields, LSB up: value[VALUE_BITS-1:0], zero pad to a byte
    input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata fields, LSB up: character[5:0], two zero pad bits
    output logic [7:0]                          m_tdata,
    output logic                                m_tlast
);

    localparam int DIGITS = sitda_pkg::dec_digits(VALUE_BITS);
    localparam int NSTAGE = (VALUE_BITS + sitda_pkg::STEP_BITS - 1) / sitda_pkg::STEP_BITS;
    // Magnitude is zero-extended at the top so every stage does full steps.
    localparam int BIN_W  = NSTAGE * sitda_pkg::STEP_BITS;
    localparam int BCD_W  = DIGITS * sitda_pkg::DIGIT_W;

    // Chain index 0 is the magnitude stage output, NSTAGE the last dabble.
    logic             chain_valid [NSTAGE+1];
    logic             chain_ready [NSTAGE+1];
    logic [BCD_W-1:0] chain_bcd   [NSTAGE+1];
    logic [BIN_W-1:0] chain_bin   [NSTAGE+1];
    logic             chain_neg   [NSTAGE+1];

    sitda_pkg::char_beat_t out_beat;

    assign chain_bcd[0] = '0;

    sitda_negate #(
        .VALUE_BITS (VALUE_BITS),
        .BIN_W      (BIN_W)
    ) u_negate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_BITS-1:0]),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_bin   (chain_bin[0]),
        .out_neg   (chain_neg[0])
    );

    // Each stage takes its input's ready from the stage after it.
    for (genvar g = 0; g < NSTAGE; g++)
    begin : g_dabble
        sitda_dabble_stage #(
            .DIGITS (DIGITS),
            .BIN_W  (BIN_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_ready  (chain_ready[g]),
            .in_bcd    (chain_bcd[g]),
            .in_bin    (chain_bin[g]),
            .in_neg    (chain_neg[g]),
            .out_valid (chain_valid[g+1]),
            .out_ready (chain_ready[g+1]),
            .out_bcd   (chain_bcd[g+1]),
            .out_bin   (chain_bin[g+1]),
            .out_neg   (chain_neg[g+1])
        );
    end

    // Binary field of the last stage is fully shifted out; only BCD and
    // sign go on.
    sitda_emitter #(
        .DIGITS (DIGITS)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[NSTAGE]),
        .in_ready  (chain_ready[NSTAGE]),
        .in_bcd    (chain_bcd[NSTAGE]),
        .in_neg    (chain_neg[NSTAGE]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat)
    );

    assign m_tdata = {2'b00, out_beat.character};
    assign m_tlast = out_beat.last_char;

endmodule
